[rtl/core/amnco_pkg.sv]
package amnco_pkg;

  // sine table shape
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_FRAC_BITS  = 15;
  localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
  localparam int ADDR_W          = SINE_TABLE_BITS - 1;
  localparam int POS_W           = SINE_TABLE_BITS - 2;

  // datapath widths
  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int BIAS_W   = 16;
  localparam int M_W      = 18;
  localparam int SINE_W   = SINE_FRAC_BITS + 1;
  localparam int PROD_W   = M_W + SINE_W;
  localparam int SHIFT    = SINE_FRAC_BITS + 1;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_BIAS    = 2'd1;

  localparam logic [PHASE_W-1:0] PHASE_INCREMENT_RESET = 32'd536870912;
  localparam logic [BIAS_W-1:0]  CARRIER_BIAS_RESET    = 16'd32768;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_FRAC_BITS-1:0] sine_table_t [QUARTER_LEN+1];

  // one Taylor step: term scaled by a^2 in q30; the caller divides by the factorial ratio
  function automatic logic [63:0] taylor_next(logic [63:0] term, logic [63:0] a2);
    logic [63:0] p;
    p = (term * a2) >> 30;
    return p;
  endfunction

  // sin(pi/2 * k/Q) in Q0.SINE_FRAC_BITS, evaluated in Q30
  function automatic logic [SINE_FRAC_BITS-1:0] fixed_sine(int k);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] maxv;
    a    = (HALF_PI_Q30 * 64'(k)) >> POS_W;
    a2   = (a * a) >> 30;
    maxv = (64'd1 << SINE_FRAC_BITS) - 64'd1;
    sum  = a;
    term = taylor_next(a, a2) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, a2) / 64'd20;
    sum  = sum + term;
    term = taylor_next(term, a2) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, a2) / 64'd72;
    sum  = sum + term;
    term = taylor_next(term, a2) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, a2) / 64'd156;
    sum  = sum + term;
    term = taylor_next(term, a2) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    v = ((sum << SINE_FRAC_BITS) + (64'd1 << 29)) >> 30;
    if (v > maxv) begin
      v = maxv;
    end
    return v[SINE_FRAC_BITS-1:0];
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      t[k] = fixed_sine(k);
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

[rtl/core/am_modulator_nco_top.sv]
// am modulator with nco sine carrier
// stages: the result passes the phase/sum, table, multiply and saturate registers in that order
// throughput: one sample per cycle; the four-stage pipeline moves as one, held by out_stall
// reset: synchronous active-high rst clears the phase accumulator and pipeline valids and
//   loads phase_increment = 2^29 and carrier_bias = 32768
module am_modulator_nco_top
  import amnco_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  // sample input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] audio_sample,
  // modulated output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out
);

  logic [PHASE_W-1:0] phase_increment;
  logic [BIAS_W-1:0]  carrier_bias;
  logic [PHASE_W-1:0] carrier_phase;
  logic [PHASE_W-1:0] carrier_phase_next;

  logic                       advance;
  logic                       in_xfer;

  logic                       s1_valid;
  logic signed [M_W-1:0]      s1_m;
  logic [SINE_TABLE_BITS-1:0] s1_idx;

  logic                       s2_valid;
  logic signed [M_W-1:0]      s2_m;
  logic signed [SINE_W-1:0]   s2_sine;

  logic                       s3_valid;
  logic signed [PROD_W-1:0]   s3_prod;

  logic signed [SAMPLE_W-1:0] out_val;

  logic signed [M_W-1:0]      m_next;
  logic [1:0]                 quadrant;
  logic [POS_W-1:0]           pos;
  logic [ADDR_W-1:0]          addr;
  logic [SINE_FRAC_BITS-1:0]  mag;
  logic signed [SINE_W-1:0]   sine_next;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   trunc;
  logic signed [SAMPLE_W-1:0] out_val_next;

  // whole pipeline moves together unless the result is held
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign in_xfer  = in_valid && advance;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= PHASE_INCREMENT_RESET;
      carrier_bias    <= CARRIER_BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_INCREMENT: phase_increment <= cfg_data;
        REG_CARRIER_BIAS:    carrier_bias    <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator and bias sum
  assign carrier_phase_next = carrier_phase + phase_increment;
  assign m_next = $signed({2'b00, carrier_bias}) + M_W'(audio_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
    end else if (in_xfer) begin
      carrier_phase <= carrier_phase_next;
    end
  end

  // quarter-wave lookup with quadrant symmetry
  assign quadrant  = s1_idx[SINE_TABLE_BITS-1 -: 2];
  assign pos       = s1_idx[POS_W-1:0];
  assign addr      = quadrant[0] ? (ADDR_W'(QUARTER_LEN) - {1'b0, pos}) : {1'b0, pos};
  assign mag       = SINE_TABLE[addr];
  assign sine_next = quadrant[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // product
  assign prod_next = PROD_W'(s2_m) * PROD_W'(s2_sine);

  // truncate toward zero, then saturate
  always_comb begin
    trunc = (s3_prod + (s3_prod[PROD_W-1] ? PROD_W'((1 << SHIFT) - 1) : PROD_W'(0)))
            >>> SHIFT;
    if (trunc > PROD_W'(32767)) begin
      out_val_next = 16'sh7fff;
    end else if (trunc < -PROD_W'(32768)) begin
      out_val_next = 16'sh8000;
    end else begin
      out_val_next = trunc[SAMPLE_W-1:0];
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_m    <= m_next;
      s1_idx  <= carrier_phase_next[PHASE_W-1 -: SINE_TABLE_BITS];
      s2_m    <= s1_m;
      s2_sine <= sine_next;
      s3_prod <= prod_next;
      out_val <= out_val_next;
    end
  end

  assign left_out  = out_val;
  assign right_out = out_val;

endmodule

[bench/testbench.sv]
module testbench;
  import amnco_pkg::*;

  // config indexes past the two real registers, written to check they are ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int PIPE_LATENCY = 4;
  localparam int PHASE_ITEMS  = 250;
  localparam int PHASE_COUNT  = 7;
  localparam int LONG_HOLD    = 80;

  // expected modulated samples plus the carrier state that produces them
  class am_scoreboard;
    logic [PHASE_W-1:0]         phase_step;
    logic [BIAS_W-1:0]          bias;
    logic [PHASE_W-1:0]         phase_acc;
    int unsigned                sine_mag[QUARTER_LEN+1];
    logic signed [SAMPLE_W-1:0] modulated_q[$];
    int                         fails;

    function new();
      phase_step = PHASE_INCREMENT_RESET;
      bias       = CARRIER_BIAS_RESET;
      phase_acc  = '0;
      fails      = 0;
      for (int k = 0; k <= QUARTER_LEN; k++) begin
        sine_mag[k] = quarter_sine(k);
      end
    endfunction

    // taylor series of sin(pi/2 * k/Q) in q30, rounded to the table's fraction bits
    function int unsigned quarter_sine(int k);
      bit [63:0] ang;
      bit [63:0] ang2;
      bit [63:0] term;
      bit [63:0] acc;
      bit [63:0] v;
      ang  = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_LEN);
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = (acc >= term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
      v = ((acc << SINE_FRAC_BITS) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << SINE_FRAC_BITS) - 64'd1) begin
        v = (64'd1 << SINE_FRAC_BITS) - 64'd1;
      end
      return int'(v);
    endfunction

    // quadrant symmetry over the quarter-wave table
    function longint sine_at(logic [PHASE_W-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0]                 quadrant;
      int                         pos;
      longint                     mag;
      idx      = ph[PHASE_W-1 -: SINE_TABLE_BITS];
      quadrant = idx[SINE_TABLE_BITS-1 -: 2];
      pos      = int'(idx[POS_W-1:0]);
      mag      = quadrant[0] ? sine_mag[QUARTER_LEN - pos] : sine_mag[pos];
      return quadrant[1] ? -mag : mag;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PHASE_INCREMENT: phase_step = data;
        REG_CARRIER_BIAS:    bias = data[BIAS_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the carrier and queue the modulated sample for one accepted input
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint m;
      longint prod;
      longint val;
      phase_acc = phase_acc + phase_step;
      m         = longint'(bias) + longint'(s);
      prod      = m * sine_at(phase_acc);
      // truncate toward zero
      if (prod < 0) begin
        val = -((-prod) >> SHIFT);
      end else begin
        val = prod >> SHIFT;
      end
      if (val > 32767) begin
        val = 32767;
      end
      if (val < -32768) begin
        val = -32768;
      end
      modulated_q.push_back(SAMPLE_W'(val));
    endfunction

    function int pending();
      return modulated_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      logic signed [SAMPLE_W-1:0] want;
      if (modulated_q.size() == 0) begin
        report($sformatf("result left=%0d right=%0d with nothing outstanding", l, r));
      end else begin
        want = modulated_q.pop_front();
        if (l !== want) begin
          report($sformatf("left_out %0d, predicted %0d", l, want));
        end
        if (r !== want) begin
          report($sformatf("right_out %0d, predicted %0d", r, want));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] audio_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  am_scoreboard sb;
  bit           idle_en  = 1'b0;
  int           hold_len = 0;

  am_modulator_nco_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .audio_sample (audio_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  always #5 clk = ~clk;

  // receiver: random stall bursts, plus a long hold-off when requested
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (hold_len > 0) begin
          stall_left = hold_len;
          hold_len   = 0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 6);
        end
      end
    end
  end

  // check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(left_out, right_out);
    end
  end

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    audio_sample <= s;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_sample(s);
  endtask

  // cfg_valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    sb.write_reg(idx, data);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [PHASE_W-1:0] step;
    logic [BIAS_W-1:0]  b;
    case ($urandom_range(0, 7))
      0:       step = '0;
      1:       step = '1;
      2:       step = $urandom_range(1, 4096);
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0:       b = '0;
      1:       b = '1;
      default: b = $urandom_range(0, 65535);
    endcase
    write_reg(REG_PHASE_INCREMENT, step);
    write_reg(REG_CARRIER_BIAS, {16'h0000, b});
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_SPARE_3, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // a stream of random samples; optionally a full drain or a long output hold midway
  task automatic run_stream(input int count, input bit drain_mid, input bit hold_mid);
    for (int i = 0; i < count; i++) begin
      if (drain_mid && i == count / 2) begin
        in_valid <= 1'b0;
        wait_drain();
      end
      if (hold_mid && i == count / 3) begin
        hold_len = LONG_HOLD;
      end
      send_sample(pick_sample());
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] reset_cfg_samples[8];
    logic signed [SAMPLE_W-1:0] wrap_samples[4];
    sb = new();
    reset_cfg_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1,
                          16'sd1, 16'sh4000, -16'sd16385, 16'sd12345};
    wrap_samples      = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, phase steps of an eighth period
    foreach (reset_cfg_samples[i]) begin
      send_sample(reset_cfg_samples[i]);
    end
    in_valid <= 1'b0;
    wait_drain();

    // full bias, quarter steps: saturation on both signs and quadrant edges
    write_reg(REG_PHASE_INCREMENT, 32'h4000_0000);
    write_reg(REG_CARRIER_BIAS, 32'h0000_ffff);
    cfg_valid <= 1'b0;
    repeat (4) send_sample(16'sh7fff);
    repeat (2) send_sample(16'sh8000);
    in_valid <= 1'b0;
    wait_drain();

    // zero bias, max increment wraps the phase; spare indexes must change nothing
    write_reg(REG_PHASE_INCREMENT, 32'hffff_ffff);
    write_reg(REG_CARRIER_BIAS, 32'h0000_0000);
    write_reg(REG_SPARE_2, $urandom);
    write_reg(REG_SPARE_3, 32'hffff_ffff);
    cfg_valid <= 1'b0;
    foreach (wrap_samples[i]) begin
      send_sample(wrap_samples[i]);
    end
    in_valid <= 1'b0;
    wait_drain();

    // zero increment holds the carrier still
    write_reg(REG_PHASE_INCREMENT, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    in_valid <= 1'b0;
    wait_drain();

    // random streams, idling off in the last one
    idle_en = 1'b1;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT - 1) begin
        idle_en = 1'b0;
      end
      random_config();
      run_stream(PHASE_ITEMS, p == 1, p == 2);
      wait_drain();
    end

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
